[design/mp2a_pkg.sv]
`default_nettype none
package mp2a_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_WINDOW      = 8;

	localparam int PHASE_BITS   = 3;
	localparam int WIN_BITS     = 4;
	localparam int DIM_BITS     = 11;
	localparam int IDX_BITS     = 10;
	localparam int ARG_BITS     = 2 * PHASE_BITS;
	localparam int DIV_BITS     = 13;
	localparam int CFG_IDX_BITS = 3;
	localparam int OUTQ_DEPTH   = 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIN_H = 3'd0,
		REG_WIN_W = 3'd1,
		REG_IMG_W = 3'd2,
		REG_IMG_H = 3'd3
	} cfg_reg_t;

	localparam logic [WIN_BITS-1:0] WIN_H_RST = 4'd2;
	localparam logic [WIN_BITS-1:0] WIN_W_RST = 4'd2;
	localparam logic [DIM_BITS-1:0] IMG_W_RST = 11'd28;
	localparam logic [DIM_BITS-1:0] IMG_H_RST = 11'd28;

	typedef struct packed {
		logic vld;
		logic first_row;
		logic last_row;
	} line_ctl_t;

	// Quotient by a window size of 1..8 through a rounded-up reciprocal; exact for x below 2**13
	function automatic logic [DIV_BITS-1:0] div_small(input logic [DIV_BITS-1:0] x,
			input logic [WIN_BITS-1:0] d);
		logic [16:0]          m;
		logic [DIV_BITS+16:0] p;
		unique case (d)
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd5:    m = 17'd13108;
			4'd6:    m = 17'd10923;
			4'd7:    m = 17'd9363;
			4'd8:    m = 17'd8192;
			default: m = 17'd65536;
		endcase
		p = (DIV_BITS+17)'(x) * (DIV_BITS+17)'(m);
		return p[DIV_BITS+15:16];
	endfunction

endpackage
`default_nettype wire

[design/max_pool_2d_argmax_top.sv]
// A result is registered in the line stage and then in the result queue before it appears on
// m_axis; when the result queue is empty, no earlier result waits ahead of it.
// Throughput: one sample per cycle while s_axis_tready is high; the line memory does one
// read-modify-write per cycle, with the previous write bypassed when the same pooled column
// is hit again at once. Reset: counters, phases and window state clear, registers return to
// 2, 2, 28, 28; the line memory is not cleared. s_axis is held off after reset and after each
// configuration write while the window limits settle.
`default_nettype none
module max_pool_2d_argmax_top #(
	parameter int MAX_WIDTH   = mp2a_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = mp2a_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       s_axis_tvalid,
	output logic                                            s_axis_tready,
	// sample
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_axis_tdata,
	// frame_start
	input  wire logic                                       s_axis_tuser,
	output logic                                            m_axis_tvalid,
	input  wire logic                                       m_axis_tready,
	// pooled_max, max_row_offset, max_col_offset, out_col, out_row
	output logic [((SAMPLE_BITS+2*mp2a_pkg::IDX_BITS+mp2a_pkg::ARG_BITS+7)/8)*8-1:0]
	                                                        m_axis_tdata,
	input  wire logic                                       cfg_valid,
	output logic                                            cfg_ready,
	input  wire logic [mp2a_pkg::CFG_IDX_BITS-1:0]          cfg_index,
	input  wire logic [mp2a_pkg::DIM_BITS-1:0]              cfg_data
);
	import mp2a_pkg::*;

	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int IW       = $clog2(MAX_WIDTH + 1);
	localparam int RES_BITS = SAMPLE_BITS + ARG_BITS + 2 * IDX_BITS;
	localparam int OUT_TW   = ((RES_BITS + 7) / 8) * 8;

	logic [WIN_BITS-1:0] win_h, win_w;
	logic [IW-1:0]       img_w, img_h, col_lim, row_lim;
	logic                settled, room, accept;

	line_ctl_t                     ctl;
	logic signed [SAMPLE_BITS-1:0] seg_max;
	logic [ARG_BITS-1:0]           seg_arg;
	logic [CW-1:0]                 col_idx;
	logic [IDX_BITS-1:0]           row_idx;

	logic                   res_vld;
	logic [SAMPLE_BITS-1:0] res_max;
	logic [ARG_BITS-1:0]    res_arg;
	logic [IDX_BITS-1:0]    res_col, res_row;
	logic [RES_BITS-1:0]    res_word, q_data;

	assign s_axis_tready = settled && room;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mp2a_cfg #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.win_h     (win_h),
		.win_w     (win_w),
		.img_w     (img_w),
		.img_h     (img_h),
		.col_lim   (col_lim),
		.row_lim   (row_lim),
		.settled   (settled)
	);

	mp2a_scan #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
		.frame_start (s_axis_tuser),
		.win_h       (win_h),
		.win_w       (win_w),
		.img_w       (img_w),
		.img_h       (img_h),
		.col_lim     (col_lim),
		.row_lim     (row_lim),
		.ctl         (ctl),
		.seg_max     (seg_max),
		.seg_arg     (seg_arg),
		.col_idx     (col_idx),
		.row_idx     (row_idx)
	);

	mp2a_line #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.seg_max (seg_max),
		.seg_arg (seg_arg),
		.col_idx (col_idx),
		.row_idx (row_idx),
		.res_vld (res_vld),
		.res_max (res_max),
		.res_arg (res_arg),
		.res_col (res_col),
		.res_row (res_row)
	);

	// argmax holds the row offset above the column offset
	assign res_word = {res_row, res_col, res_arg[PHASE_BITS-1:0],
		res_arg[ARG_BITS-1:PHASE_BITS], res_max};

	mp2a_outq #(
		.WIDTH(RES_BITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data (res_word),
		.pend      (res_vld),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (q_data)
	);

	assign m_axis_tdata = OUT_TW'(q_data);

	a_cfg_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !s_axis_tready)
		else $error("sample transfer taken before window limits settled");

	a_issue_needs_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld |-> (s_axis_tvalid && settled && room))
		else $error("line update issued without an input transfer");

endmodule
`default_nettype wire

[design/mp2a_ram.sv]
`default_nettype none
module mp2a_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents when both ports hit the same entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/mp2a_cfg.sv]
`default_nettype none
module mp2a_cfg #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mp2a_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [mp2a_pkg::DIM_BITS-1:0]        cfg_data,
	output logic      [mp2a_pkg::WIN_BITS-1:0]        win_h,
	output logic      [mp2a_pkg::WIN_BITS-1:0]        win_w,
	output logic      [$clog2(MAX_WIDTH+1)-1:0]       img_w,
	output logic      [$clog2(MAX_WIDTH+1)-1:0]       img_h,
	output logic      [$clog2(MAX_WIDTH+1)-1:0]       col_lim,
	output logic      [$clog2(MAX_WIDTH+1)-1:0]       row_lim,
	output logic                                      settled
);
	import mp2a_pkg::*;

	localparam int IW = $clog2(MAX_WIDTH + 1);

	logic [WIN_BITS-1:0] win_h_q, win_w_q;
	logic [DIM_BITS-1:0] img_w_q, img_h_q;
	logic [1:0]          settle_q;

	logic [WIN_BITS-1:0] wh_c, ww_c;
	logic [IW-1:0]       iw_c, ih_c;
	logic [WIN_BITS-1:0] wh_s1, ww_s1;
	logic [IW-1:0]       iw_s1, ih_s1;
	logic [DIV_BITS-1:0] qc_s1, qr_s1;
	logic [IW-1:0]       col_lim_s2, row_lim_s2;
	logic [DIV_BITS+WIN_BITS-1:0] col_prod, row_prod;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_h_q  <= WIN_H_RST;
			win_w_q  <= WIN_W_RST;
			img_w_q  <= IMG_W_RST;
			img_h_q  <= IMG_H_RST;
			settle_q <= 2'd2;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIN_H: win_h_q <= cfg_data[WIN_BITS-1:0];
				REG_WIN_W: win_w_q <= cfg_data[WIN_BITS-1:0];
				REG_IMG_W: img_w_q <= cfg_data;
				REG_IMG_H: img_h_q <= cfg_data;
				default: ;
			endcase
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	always_comb begin
		wh_c = (win_h_q == '0) ? WIN_BITS'(1) :
			(32'(win_h_q) > MAX_WINDOW) ? WIN_BITS'(MAX_WINDOW) : win_h_q;
		ww_c = (win_w_q == '0) ? WIN_BITS'(1) :
			(32'(win_w_q) > MAX_WINDOW) ? WIN_BITS'(MAX_WINDOW) : win_w_q;
		iw_c = (img_w_q == '0) ? IW'(1) :
			(32'(img_w_q) > MAX_WIDTH) ? IW'(MAX_WIDTH) : IW'(img_w_q);
		ih_c = (img_h_q == '0) ? IW'(1) :
			(32'(img_h_q) > MAX_WIDTH) ? IW'(MAX_WIDTH) : IW'(img_h_q);
	end

	// Whole-window limits: size rounded down to a multiple of the window
	always_ff @(posedge clk) begin
		wh_s1 <= wh_c;
		ww_s1 <= ww_c;
		iw_s1 <= iw_c;
		ih_s1 <= ih_c;
		qc_s1 <= div_small(DIV_BITS'(iw_c), ww_c);
		qr_s1 <= div_small(DIV_BITS'(ih_c), wh_c);
		col_lim_s2 <= IW'(col_prod);
		row_lim_s2 <= IW'(row_prod);
	end

	assign col_prod = (DIV_BITS+WIN_BITS)'(qc_s1) * (DIV_BITS+WIN_BITS)'(ww_s1);
	assign row_prod = (DIV_BITS+WIN_BITS)'(qr_s1) * (DIV_BITS+WIN_BITS)'(wh_s1);

	assign win_h   = wh_s1;
	assign win_w   = ww_s1;
	assign img_w   = iw_s1;
	assign img_h   = ih_s1;
	assign col_lim = col_lim_s2;
	assign row_lim = row_lim_s2;
	assign settled = (settle_q == 2'd0);

endmodule
`default_nettype wire

[design/mp2a_scan.sv]
`default_nettype none
module mp2a_scan #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_WIDTH   = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                frame_start,
	input  wire logic [mp2a_pkg::WIN_BITS-1:0]       win_h,
	input  wire logic [mp2a_pkg::WIN_BITS-1:0]       win_w,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      img_h,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      col_lim,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      row_lim,
	output mp2a_pkg::line_ctl_t                      ctl,
	output logic signed [SAMPLE_BITS-1:0]            seg_max,
	output logic      [mp2a_pkg::ARG_BITS-1:0]       seg_arg,
	output logic      [$clog2(MAX_WIDTH)-1:0]        col_idx,
	output logic      [mp2a_pkg::IDX_BITS-1:0]       row_idx
);
	import mp2a_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]                cc_q, rc_q;
	logic [PHASE_BITS-1:0]        cp_q, rp_q;
	logic signed [SAMPLE_BITS-1:0] seg_max_q;
	logic [ARG_BITS-1:0]          seg_arg_q;

	logic [CW-1:0]         c, r;
	logic [PHASE_BITS-1:0] cp, rp;
	logic [DIV_BITS-1:0]   c_x, r_x, col_q, row_q;
	logic [WIN_BITS-1:0]   cp_inc, rp_inc;
	logic                  in_win, seg_end, take, row_end, frame_end;
	logic signed [SAMPLE_BITS-1:0] new_max;
	logic [ARG_BITS-1:0]   new_arg;

	always_comb begin
		// a frame start moves the sample to row 0, column 0
		c  = frame_start ? '0 : cc_q;
		r  = frame_start ? '0 : rc_q;
		cp = frame_start ? '0 : cp_q;
		rp = frame_start ? '0 : rp_q;
		c_x = DIV_BITS'(c);
		r_x = DIV_BITS'(r);
		cp_inc = WIN_BITS'(cp) + WIN_BITS'(1);
		rp_inc = WIN_BITS'(rp) + WIN_BITS'(1);
		in_win  = (c_x < DIV_BITS'(col_lim)) && (r_x < DIV_BITS'(row_lim));
		seg_end = in_win && (cp_inc >= win_w);
		take    = (cp == '0) || (sample > seg_max_q);
		new_max = take ? sample : seg_max_q;
		new_arg = take ? {rp, cp} : seg_arg_q;
		col_q   = div_small(c_x, win_w);
		row_q   = div_small(r_x, win_h);
		row_end   = (c_x + DIV_BITS'(1)) >= DIV_BITS'(img_w);
		frame_end = (r_x + DIV_BITS'(1)) >= DIV_BITS'(img_h);
	end

	assign ctl = '{
		vld:       accept && seg_end,
		first_row: (rp == '0),
		last_row:  (rp_inc >= win_h)
	};
	assign seg_max = new_max;
	assign seg_arg = new_arg;
	assign col_idx = col_q[CW-1:0];
	assign row_idx = row_q[IDX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q      <= '0;
			rc_q      <= '0;
			cp_q      <= '0;
			rp_q      <= '0;
			seg_max_q <= '0;
			seg_arg_q <= '0;
		end else if (accept) begin
			if (in_win) begin
				seg_max_q <= new_max;
				seg_arg_q <= new_arg;
			end
			if (row_end) begin
				cc_q <= '0;
				cp_q <= '0;
				if (frame_end) begin
					rc_q <= '0;
					rp_q <= '0;
				end else begin
					rc_q <= CW'(r_x + DIV_BITS'(1));
					rp_q <= (rp_inc >= win_h) ? '0 : rp_inc[PHASE_BITS-1:0];
				end
			end else begin
				cc_q <= CW'(c_x + DIV_BITS'(1));
				rc_q <= r;
				rp_q <= rp;
				cp_q <= (cp_inc >= win_w) ? '0 : cp_inc[PHASE_BITS-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[design/mp2a_line.sv]
`default_nettype none
module mp2a_line #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_WIDTH   = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mp2a_pkg::line_ctl_t                 ctl,
	input  wire logic signed [SAMPLE_BITS-1:0]       seg_max,
	input  wire logic [mp2a_pkg::ARG_BITS-1:0]       seg_arg,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]        col_idx,
	input  wire logic [mp2a_pkg::IDX_BITS-1:0]       row_idx,
	output logic                                     res_vld,
	output logic      [SAMPLE_BITS-1:0]              res_max,
	output logic      [mp2a_pkg::ARG_BITS-1:0]       res_arg,
	output logic      [mp2a_pkg::IDX_BITS-1:0]       res_col,
	output logic      [mp2a_pkg::IDX_BITS-1:0]       res_row
);
	import mp2a_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = SAMPLE_BITS + ARG_BITS;

	line_ctl_t                     ctl_s1;
	logic signed [SAMPLE_BITS-1:0] seg_s1;
	logic [ARG_BITS-1:0]           arg_s1;
	logic [CW-1:0]                 col_s1;
	logic [IDX_BITS-1:0]           row_s1;

	logic          wr_vld_q;
	logic [CW-1:0] wr_addr_q;
	logic [LW-1:0] wr_data_q;

	logic [LW-1:0] rd_data, stored, wdata;
	logic          take, we;
	logic signed [SAMPLE_BITS-1:0] stored_max;

	mp2a_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (we),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (ctl.vld),
		.raddr (col_idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			wr_vld_q <= 1'b0;
		end else begin
			ctl_s1   <= ctl;
			wr_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1    <= seg_max;
		arg_s1    <= seg_arg;
		col_s1    <= col_idx;
		row_s1    <= row_idx;
		wr_addr_q <= col_s1;
		wr_data_q <= wdata;
	end

	always_comb begin
		// bypass the write of the previous cycle, which the memory read missed
		stored     = (wr_vld_q && (wr_addr_q == col_s1)) ? wr_data_q : rd_data;
		stored_max = $signed(stored[SAMPLE_BITS-1:0]);
		take       = ctl_s1.first_row || (seg_s1 > stored_max);
		wdata      = take ? {arg_s1, seg_s1} : stored;
		we         = ctl_s1.vld && take;
	end

	assign res_vld = ctl_s1.vld && ctl_s1.last_row;
	assign res_max = wdata[SAMPLE_BITS-1:0];
	assign res_arg = wdata[LW-1:SAMPLE_BITS];
	assign res_col = IDX_BITS'(col_s1);
	assign res_row = row_s1;

endmodule
`default_nettype wire

[design/mp2a_outq.sv]
`default_nettype none
module mp2a_outq #(
	parameter int WIDTH = 42
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pend,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [WIDTH-1:0] out_data
);
	import mp2a_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);
	localparam int NW = $clog2(OUTQ_DEPTH + 1);

	logic [WIDTH-1:0] buf_q [OUTQ_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// a new item needs a slot for itself and for a result still in the line stage
	assign room = ((NW+1)'(cnt_q) + (NW+1)'(pend)) < (NW+1)'(OUTQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (cnt_q == NW'(OUTQ_DEPTH))))
		else $error("result queue overflow");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q == NW'($past(cnt_q) + NW'($past(push)) - NW'($past(pop)))))
		else $error("result queue fill count lost a transfer");

endmodule
`default_nettype wire
